// ===== rtl/core/ibfr_pkg.sv =====
// shared types and constants of the serial frame receiver
package ibfr_pkg;

   // field widths
   localparam int DATA_W     = 8;
   localparam int IDX_W      = 4;
   localparam int VALUE_W    = 16;
   localparam int LIMIT_W    = 24;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   // input operation codes
   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // register map
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_HEADER_FIRST  = 2'd0,
      REG_HEADER_SECOND = 2'd1,
      REG_DEAD_LIMIT    = 2'd2,
      REG_DEFAULT_VALUE = 2'd3
   } csr_reg_type;

   // register reset values
   localparam logic [DATA_W-1:0]  HEADER_FIRST_RST  = 8'h20;
   localparam logic [DATA_W-1:0]  HEADER_SECOND_RST = 8'h40;
   localparam logic [LIMIT_W-1:0] DEAD_LIMIT_RST    = 24'd1000;
   localparam logic [VALUE_W-1:0] DEFAULT_VALUE_RST = 16'd1500;

   // idle counter saturates here
   localparam logic [LIMIT_W-1:0] IDLE_MAX = 24'hFF_FFFF;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EMIT,
      ST_DRAIN
   } ctl_state_type;

   // controller to datapath
   typedef struct packed {
      logic step_en;   // input transfer this cycle
      logic k_clear;   // restart channel counter
      logic issue;     // read the next channel into the result pipeline
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic run_start;  // current input item would start a result run
      logic last_issue; // channel counter sits on the final channel
      logic advance;    // result pipeline may move this cycle
      logic pipe_empty; // no result in flight
   } dp_sts_type;

endpackage

// ===== rtl/core/ibfr_if.sv =====
// channel interfaces of the serial frame receiver

// input item channel
interface ibfr_req_if;
   import ibfr_pkg::*;
   logic              valid;
   logic              ready;
   logic              op;
   logic [DATA_W-1:0] data_byte;

   modport source (output valid, output op, output data_byte, input ready);
   modport sink   (input valid, input op, input data_byte, output ready);
endinterface

// result item channel
interface ibfr_rsp_if;
   import ibfr_pkg::*;
   logic               valid;
   logic               ready;
   logic [IDX_W-1:0]   channel_index;
   logic [VALUE_W-1:0] channel_value;
   logic               is_failsafe;
   logic               link_alive;
   logic               last;

   modport source (output valid, output channel_index, output channel_value,
                   output is_failsafe, output link_alive, output last, input ready);
   modport sink   (input valid, input channel_index, input channel_value,
                   input is_failsafe, input link_alive, input last, output ready);
endinterface

// configuration write channel
interface ibfr_csr_if;
   import ibfr_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/ibfr_ctl.sv =====
// controller of the serial frame receiver: input acceptance and result run sequencing
module ibfr_ctl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  ibfr_pkg::dp_sts_type sts,
   output ibfr_pkg::ctl_cmd_type cmd
);
   import ibfr_pkg::*;

   ctl_state_type state_ff;
   ctl_state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && sts.run_start) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (sts.advance && sts.last_issue) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (sts.pipe_empty) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready   = 1'b0;
      cmd.step_en = 1'b0;
      cmd.k_clear = 1'b0;
      cmd.issue   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.step_en = req_valid;
            cmd.k_clear = req_valid && sts.run_start;
         end
         ST_EMIT: begin
            cmd.issue = sts.advance;
         end
         ST_DRAIN: begin
            req_ready = 1'b0;
         end
         default: req_ready = 1'b0;
      endcase
   end

endmodule

// ===== rtl/core/ibfr_dp.sv =====
// datapath of the serial frame receiver: registers, frame state, frame store, result pipeline
module ibfr_dp #(
   parameter int CHANNELS    = 14,
   parameter int FRAME_BYTES = 30
) (
   input  logic                            clock,
   input  logic                            reset,
   input  ibfr_pkg::ctl_cmd_type           cmd,
   output ibfr_pkg::dp_sts_type            sts,
   input  logic                            req_op,
   input  logic [ibfr_pkg::DATA_W-1:0]     req_data_byte,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [ibfr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ibfr_pkg::CSR_DATA_W-1:0] csr_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [ibfr_pkg::IDX_W-1:0]      rsp_channel_index,
   output logic [ibfr_pkg::VALUE_W-1:0]    rsp_channel_value,
   output logic                            rsp_is_failsafe,
   output logic                            rsp_link_alive,
   output logic                            rsp_last
);
   import ibfr_pkg::*;

   localparam int STORE_BYTES = 2 * CHANNELS;
   localparam int CNT_W       = $clog2(FRAME_BYTES);
   localparam int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   // configuration registers
   logic [DATA_W-1:0]  header_first_ff;
   logic [DATA_W-1:0]  header_second_ff;
   logic [LIMIT_W-1:0] dead_limit_ff;
   logic [VALUE_W-1:0] default_value_ff;

   // frame state
   logic               header_pending_ff;
   logic               collecting_ff;
   logic [CNT_W-1:0]   byte_count_ff;
   logic               alive_ff;
   logic [LIMIT_W-1:0] idle_count_ff;
   logic               failsafe_ff;

   // frame store, one 16-bit word per channel
   logic [VALUE_W-1:0] store_mem [CHANNELS];

   // result pipeline
   logic [CH_W-1:0]    k_ff;
   logic               rd_valid_ff;
   logic [CH_W-1:0]    rd_index_ff;
   logic               rd_last_ff;
   logic [VALUE_W-1:0] rd_data_ff;
   logic               out_valid_ff;
   logic [IDX_W-1:0]   out_index_ff;
   logic [VALUE_W-1:0] out_value_ff;
   logic               out_last_ff;

   logic               is_byte;
   logic               frame_end;
   logic               dead_fire;
   logic               store_wr;
   logic [CH_W-1:0]    store_addr;
   logic               advance;
   logic               k_is_last;

   // item decode
   assign is_byte    = (req_op == OP_BYTE);
   assign frame_end  = collecting_ff && (byte_count_ff == CNT_W'(FRAME_BYTES - 1));
   assign dead_fire  = (idle_count_ff == dead_limit_ff) && (idle_count_ff != IDLE_MAX);
   assign store_wr   = cmd.step_en && is_byte && collecting_ff
                       && (32'(byte_count_ff) < STORE_BYTES);
   assign store_addr = CH_W'(byte_count_ff >> 1);
   assign advance    = !out_valid_ff || rsp_ready;
   assign k_is_last  = (k_ff == CH_W'(CHANNELS - 1));

   // status to controller
   assign sts.run_start  = is_byte ? frame_end : dead_fire;
   assign sts.last_issue = k_is_last;
   assign sts.advance    = advance;
   assign sts.pipe_empty = !rd_valid_ff && !out_valid_ff;

   // configuration writes
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         header_first_ff  <= HEADER_FIRST_RST;
         header_second_ff <= HEADER_SECOND_RST;
         dead_limit_ff    <= DEAD_LIMIT_RST;
         default_value_ff <= DEFAULT_VALUE_RST;
      end else if (csr_valid) begin
         case (csr_reg_type'(csr_index))
            REG_HEADER_FIRST:  header_first_ff  <= csr_data[DATA_W-1:0];
            REG_HEADER_SECOND: header_second_ff <= csr_data[DATA_W-1:0];
            REG_DEAD_LIMIT:    dead_limit_ff    <= csr_data[LIMIT_W-1:0];
            REG_DEFAULT_VALUE: default_value_ff <= csr_data[VALUE_W-1:0];
            default: ;
         endcase
      end
   end

   // header search, byte counting, idle timeout
   always_ff @(posedge clock) begin
      if (reset) begin
         header_pending_ff <= 1'b0;
         collecting_ff     <= 1'b0;
         byte_count_ff     <= '0;
         alive_ff          <= 1'b0;
         idle_count_ff     <= '0;
         failsafe_ff       <= 1'b0;
      end else if (cmd.step_en) begin
         if (is_byte) begin
            idle_count_ff <= '0;
            if (!collecting_ff) begin
               if (header_pending_ff && (req_data_byte == header_second_ff)) begin
                  header_pending_ff <= 1'b0;
                  collecting_ff     <= 1'b1;
                  byte_count_ff     <= '0;
               end else begin
                  header_pending_ff <= (req_data_byte == header_first_ff);
               end
            end else if (frame_end) begin
               collecting_ff <= 1'b0;
               byte_count_ff <= '0;
               alive_ff      <= 1'b1;
               failsafe_ff   <= 1'b0;
            end else begin
               byte_count_ff <= byte_count_ff + 1'b1;
            end
         end else begin
            if (idle_count_ff != IDLE_MAX) begin
               idle_count_ff <= idle_count_ff + 1'b1;
            end
            if (dead_fire) begin
               alive_ff    <= 1'b0;
               failsafe_ff <= 1'b1;
            end
         end
      end
   end

   // frame store write, little-endian byte lanes
   always_ff @(posedge clock) begin
      if (store_wr) begin
         if (byte_count_ff[0]) begin
            store_mem[store_addr][VALUE_W-1:DATA_W] <= req_data_byte;
         end else begin
            store_mem[store_addr][DATA_W-1:0] <= req_data_byte;
         end
      end
   end

   // frame store read
   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         rd_data_ff <= store_mem[k_ff];
      end
   end

   // channel counter
   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff <= '0;
      end else if (cmd.k_clear) begin
         k_ff <= '0;
      end else if (cmd.issue && !k_is_last) begin
         k_ff <= k_ff + 1'b1;
      end
   end

   // result pipeline control
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         rd_valid_ff  <= cmd.issue;
         out_valid_ff <= rd_valid_ff;
      end
   end

   // result pipeline payload
   always_ff @(posedge clock) begin
      if (advance) begin
         if (cmd.issue) begin
            rd_index_ff <= k_ff;
            rd_last_ff  <= k_is_last;
         end
         out_index_ff <= IDX_W'(rd_index_ff);
         out_value_ff <= failsafe_ff ? default_value_ff : rd_data_ff;
         out_last_ff  <= rd_last_ff;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_channel_index = out_index_ff;
   assign rsp_channel_value = out_value_ff;
   assign rsp_is_failsafe   = failsafe_ff;
   assign rsp_link_alive    = alive_ff;
   assign rsp_last          = out_last_ff;

endmodule

// ===== rtl/core/ibus_frame_receiver_core.sv =====
// top level of the serial frame receiver
//
//   channel  | direction | payload                                          | transfer
//   req_ch   | in        | op, data_byte                                    | valid & ready
//   rsp_ch   | out       | channel_index, channel_value, is_failsafe,       | valid & ready
//            |           | link_alive, last                                 |
//   csr_ch   | in        | index, data                                      | valid & ready
//
// an item that causes no result is accepted in ST_IDLE and req_ready stays high
// a frame end or link timeout gives a run of CHANNELS results, one a cycle at best (single
// store read port); req_ready then drops and stays low through ST_EMIT and ST_DRAIN
// a stall on rsp_ch freezes the two-stage result pipeline; req_ready stays low until
// the run is fully delivered; csr_ch is always ready
// reset is synchronous; the frame store needs no clearing pass
module ibus_frame_receiver_core #(
   parameter int CHANNELS    = 14,
   parameter int FRAME_BYTES = 30
) (
   input  logic         clock,
   input  logic         reset,
   ibfr_req_if.sink     req_ch,
   ibfr_rsp_if.source   rsp_ch,
   ibfr_csr_if.sink     csr_ch
);
   import ibfr_pkg::*;

   ctl_cmd_type cmd;
   dp_sts_type  sts;

   // sequencing
   ibfr_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // frame handling and result generation
   ibfr_dp #(
      .CHANNELS    (CHANNELS),
      .FRAME_BYTES (FRAME_BYTES)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_op            (req_ch.op),
      .req_data_byte     (req_ch.data_byte),
      .csr_valid         (csr_ch.valid),
      .csr_ready         (csr_ch.ready),
      .csr_index         (csr_ch.index),
      .csr_data          (csr_ch.data),
      .rsp_valid         (rsp_ch.valid),
      .rsp_ready         (rsp_ch.ready),
      .rsp_channel_index (rsp_ch.channel_index),
      .rsp_channel_value (rsp_ch.channel_value),
      .rsp_is_failsafe   (rsp_ch.is_failsafe),
      .rsp_link_alive    (rsp_ch.link_alive),
      .rsp_last          (rsp_ch.last)
   );

endmodule

// ===== rtl/core/ibfr_checker.sv =====
// port-level checks of the serial frame receiver, bound to the top level
module ibfr_checker #(
   parameter int CHANNELS = 14
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [ibfr_pkg::IDX_W-1:0]    rsp_channel_index,
   input logic [ibfr_pkg::VALUE_W-1:0]  rsp_channel_value,
   input logic                          rsp_is_failsafe,
   input logic                          rsp_link_alive,
   input logic                          rsp_last
);
   import ibfr_pkg::*;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_channel_value)
         && $stable(rsp_channel_index) && $stable(rsp_last))
      else $error("stalled result changed");

   // no input transfer while a run is being delivered
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input taken during result run");

   // failsafe values only while link is dead, decoded values only while alive
   a_failsafe_alive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_failsafe != rsp_link_alive))
      else $error("failsafe flag disagrees with link status");

   // last marks the final channel
   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_channel_index == IDX_W'(CHANNELS - 1))))
      else $error("last flag on wrong channel");

   // channels follow one another without gaps
   a_index_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid
         && (rsp_channel_index == IDX_W'($past(rsp_channel_index) + 1'b1)))
      else $error("channel sequence broken");

endmodule

bind ibus_frame_receiver_core ibfr_checker #(
   .CHANNELS (CHANNELS)
) u_ibfr_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_ch.ready),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_channel_index (rsp_ch.channel_index),
   .rsp_channel_value (rsp_ch.channel_value),
   .rsp_is_failsafe   (rsp_ch.is_failsafe),
   .rsp_link_alive    (rsp_ch.link_alive),
   .rsp_last          (rsp_ch.last)
);
